[rtl/core/alids_pkg.sv]
package alids_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int RIDX_W    = 6;
    localparam int STAT_W    = 3;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BADINDEX = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     odd;
        logic     capture;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELETE,
        ST_SORT
    } state_t;

endpackage

[rtl/core/alids_cell.sv]
module alids_cell
    import alids_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CW         = 7,
    parameter int IDX        = 0
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [CW-1:0]         tgt,
    input  logic [CW-1:0]         cnt,
    input  logic [WORD_WIDTH-1:0] value,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    input  logic                  left_gt,
    input  logic                  del_here,
    output logic [WORD_WIDTH-1:0] word,
    output logic                  match,
    output logic                  gt_right
);

    localparam logic PAR = (IDX % 2) != 0;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    assign word     = word_reg;
    assign match    = (word_reg == value);
    assign gt_right = $signed(word_reg) > $signed(right_word);

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (CW'(IDX) == tgt)
                begin
                    word_next = value;
                end
                else if (CW'(IDX) > tgt)
                begin
                    word_next = left_word;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (del_here)
                begin
                    word_next = right_word;
                end
            end
            CELL_SORT:
            begin
                if ((PAR == ctl.odd) && (CW'(IDX + 1) < cnt) && gt_right)
                begin
                    word_next = right_word;
                end
                else if ((PAR != ctl.odd) && (IDX > 0) && (CW'(IDX) < cnt) && left_gt)
                begin
                    word_next = left_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

[rtl/core/alids_ctrl.sv]
module alids_ctrl
    import alids_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STAT_W-1:0]     m_tuser,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  found,
    input  logic [WORD_WIDTH-1:0] rd_word,
    output cell_ctl_t             ctl,
    output logic [CW-1:0]         tgt,
    output logic [CW-1:0]         cnt,
    output logic [WORD_WIDTH-1:0] cell_value
);

    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int XW = ((CW > RIDX_W) ? CW : RIDX_W) + 1;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         phase_reg;
    logic [CW-1:0]         phase_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [STAT_W-1:0]     status_reg;
    logic [VAL_W-1:0]      rval_reg;
    logic [CNT_W-1:0]      count_reg;

    logic                  accept;
    logic                  out_load;
    logic [STAT_W-1:0]     out_status;
    logic [VAL_W-1:0]      out_rval;
    logic [OP_W-1:0]       op;
    logic [POS_W-1:0]      pos;
    logic signed [VAL_W-1:0] val_in;
    logic [RIDX_W-1:0]     ridx;
    logic                  full;
    logic                  bad_pos;
    logic                  bad_idx;
    logic                  last_phase;

    assign op     = s_tuser;
    assign pos    = s_tdata[POS_W-1:0];
    assign val_in = $signed(s_tdata[POS_W+VAL_W-1:POS_W]);
    assign ridx   = s_tdata[POS_W+VAL_W+RIDX_W-1:POS_W+VAL_W];

    assign s_tready   = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign full       = (cnt_reg >= CW'(DEPTH));
    assign bad_pos    = (pos == '0) || (PW'(pos) > (PW'(cnt_reg) + PW'(1)));
    assign bad_idx    = (XW'(ridx) >= XW'(cnt_reg)) || (XW'(ridx) >= XW'(DEPTH));
    assign last_phase = (phase_reg == (cnt_reg - CW'(1)));
    assign cell_value = WORD_WIDTH'(val_in);
    assign cnt        = cnt_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, rval_reg, count_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_DELETE))
                begin
                    state_next = ST_DELETE;
                end
                else if (accept && (op == OP_SORT) && (cnt_reg >= CW'(2)))
                begin
                    state_next = ST_SORT;
                end
            end
            ST_DELETE:
            begin
                state_next = ST_IDLE;
            end
            ST_SORT:
            begin
                if (last_phase)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl        = '{op: CELL_HOLD, odd: 1'b0, capture: 1'b0};
        tgt        = cnt_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        out_load   = 1'b0;
        out_status = STAT_OK;
        out_rval   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_APPEND:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                out_status = STAT_FULL;
                            end
                            else
                            begin
                                ctl.op   = CELL_INSERT;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                out_status = STAT_FULL;
                            end
                            else if (bad_pos)
                            begin
                                out_status = STAT_BADPOS;
                            end
                            else
                            begin
                                ctl.op   = CELL_INSERT;
                                tgt      = CW'(PW'(pos) - PW'(1));
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            ctl.capture = 1'b1;
                        end
                        OP_SORT:
                        begin
                            phase_next = '0;
                            out_load   = (cnt_reg < CW'(2));
                        end
                        OP_READ:
                        begin
                            out_load = 1'b1;
                            if (bad_idx)
                            begin
                                out_status = STAT_BADINDEX;
                            end
                            else
                            begin
                                out_rval = VAL_W'(rd_word);
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_DELETE:
            begin
                out_load = 1'b1;
                if (found)
                begin
                    ctl.op   = CELL_SHIFT_DOWN;
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    out_status = STAT_NOTFOUND;
                end
            end
            ST_SORT:
            begin
                ctl.op     = CELL_SORT;
                ctl.odd    = phase_reg[0];
                phase_next = phase_reg + CW'(1);
                out_load   = last_phase;
            end
            default:
            begin
                ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= out_status;
            rval_reg   <= out_rval;
            count_reg  <= CNT_W'(cnt_next);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_sort_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_SORT) && (cnt_reg >= CW'(2))) |=> (state_reg == ST_SORT))
        else $error("sort did not start");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |-> (phase_reg < cnt_reg))
        else $error("sort phase beyond count");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DELETE) || (state_reg == ST_SORT)) |-> !m_tvalid_reg)
        else $error("result slot busy while an operation finishes");

endmodule

[rtl/core/array_list_insert_delete_sort_top.sv]
// Append, insert, read and unused ops give a registered result in the cycle after the request is taken.
// Delete first registers the match of every occupied cell, then shifts the chain down in the delete state.
// Sort of n entries (n >= 2) runs n odd-even exchange phases of the cell row.
// One request at a time; the next is taken only in idle and once the result slot is free.
// Reset clears the entry count and the output valid; stored entries keep no reset.
module array_list_insert_delete_sort_top
    import alids_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [OP_W-1:0]      s_tuser,   // op
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, value, read_index
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [STAT_W-1:0]    m_tuser,   // status
    output logic [M_TDATA_W-1:0] m_tdata    // count, read_value
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW   = (IDXW > RIDX_W) ? IDXW : RIDX_W;

    cell_ctl_t             ctl;
    logic [CW-1:0]         tgt;
    logic [CW-1:0]         cnt;
    logic [WORD_WIDTH-1:0] cell_value;
    logic [WORD_WIDTH-1:0] words [DEPTH];
    logic [DEPTH-1:0]      gts;
    logic [DEPTH-1:0]      match_bits;
    logic [DEPTH-1:0]      below_cnt;
    logic [DEPTH-1:0]      match_reg;
    logic [DEPTH-1:0]      del_mask;
    logic [MW-1:0]         ridx_w;
    logic [WORD_WIDTH-1:0] rd_word;
    logic                  found;

    assign ridx_w   = MW'(s_tdata[POS_W+VAL_W+RIDX_W-1:POS_W+VAL_W]);
    assign rd_word  = words[ridx_w[IDXW-1:0]];
    assign found    = |match_reg;
    assign del_mask = match_reg | (~match_reg + DEPTH'(1));

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            match_reg <= match_bits & below_cnt;
        end
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;
        logic                  left_gt;

        assign below_cnt[k] = (CW'(k) < cnt);

        if (k == 0)
        begin : g_first
            assign left_word = '0;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign left_word = words[k-1];
            assign left_gt   = gts[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_inner
            assign right_word = words[k+1];
        end

        alids_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .CW         (CW),
            .IDX        (k)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .tgt        (tgt),
            .cnt        (cnt),
            .value      (cell_value),
            .left_word  (left_word),
            .right_word (right_word),
            .left_gt    (left_gt),
            .del_here   (del_mask[k]),
            .word       (words[k]),
            .match      (match_bits[k]),
            .gt_right   (gts[k])
        );
    end

    alids_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .CW         (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .found      (found),
        .rd_word    (rd_word),
        .ctl        (ctl),
        .tgt        (tgt),
        .cnt        (cnt),
        .cell_value (cell_value)
    );

endmodule
